// File: design/rau_pkg.sv
// Shared constants and types for the rational arithmetic unit.
// No dependencies; used by rau_gcd, rau_div and rational_arithmetic_unit.
package rau_pkg;
  localparam int OP_W   = 32;
  localparam int DEN_W  = OP_W - 1;
  localparam int WIDE_W = 64;
  localparam int SH_W   = 7;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_DIV0 = 1'b1;

  // handshake between the sequencer and an iterative unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;
endpackage

// File: design/rau_gcd.sv
// Binary greatest common divisor, one compare/subtract or shift per cycle.
// Depends on rau_pkg.
module rau_gcd (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rau_pkg::unit_req_t          req,
  input  logic [rau_pkg::WIDE_W-1:0]  x_in,
  input  logic [rau_pkg::WIDE_W-1:0]  y_in,
  output rau_pkg::unit_rsp_t          rsp,
  output logic [rau_pkg::WIDE_W-1:0]  g_out
);
  typedef enum logic [1:0] {G_IDLE, G_RUN, G_DONE} gstate_t;

  gstate_t                     state_r;
  logic [rau_pkg::WIDE_W-1:0]  x_r, y_r, g_r;
  logic [rau_pkg::SH_W-1:0]    k_r;

  // hold operands, strip common twos, subtract the smaller from the larger
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
    end else begin
      case (state_r)
        G_IDLE: begin
          if (req.start) begin
            x_r     <= x_in;
            y_r     <= y_in;
            k_r     <= '0;
            state_r <= G_RUN;
          end
        end
        G_RUN: begin
          if (x_r == '0 || y_r == '0) begin
            g_r     <= (x_r | y_r) << k_r;
            state_r <= G_DONE;
          end else if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1;
            y_r <= y_r >> 1;
            k_r <= k_r + 1'b1;
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (x_r >= y_r) begin
            x_r <= x_r - y_r;
          end else begin
            y_r <= y_r - x_r;
          end
        end
        G_DONE:  state_r <= G_IDLE;
        default: state_r <= G_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state_r != G_IDLE);
  assign rsp.done = (state_r == G_DONE);
  assign g_out    = g_r;
endmodule

// File: design/rau_div.sv
// Restoring divider, one quotient bit per cycle; divisor must be non-zero.
// Depends on rau_pkg.
module rau_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rau_pkg::unit_req_t          req,
  input  logic [rau_pkg::WIDE_W-1:0]  dividend,
  input  logic [rau_pkg::WIDE_W-1:0]  divisor,
  output rau_pkg::unit_rsp_t          rsp,
  output logic [rau_pkg::WIDE_W-1:0]  quotient
);
  logic                        run_r, done_r;
  logic [rau_pkg::SH_W-1:0]    cnt_r;
  logic [rau_pkg::WIDE_W:0]    rem_r, rem_sh;
  logic [rau_pkg::WIDE_W-1:0]  quo_r, dsr_r;

  assign rem_sh = {rem_r[rau_pkg::WIDE_W-1:0], quo_r[rau_pkg::WIDE_W-1]};

  // shift in one dividend bit, subtract where it fits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !run_r) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        quo_r <= dividend;
        dsr_r <= divisor;
      end else if (run_r) begin
        if (rem_sh >= {1'b0, dsr_r}) begin
          rem_r <= rem_sh - {1'b0, dsr_r};
          quo_r <= {quo_r[rau_pkg::WIDE_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[rau_pkg::WIDE_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rau_pkg::SH_W'(rau_pkg::WIDE_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = run_r;
  assign rsp.done = done_r;
  assign quotient = quo_r;
endmodule

// File: design/rational_arithmetic_unit.sv
// Rational arithmetic unit: add, subtract, multiply or divide, reduced by gcd.
// Sequence: the multiply states S_MUL1 to S_MUL3, a binary gcd of
// subtract/shift steps, then two divisions by the gcd.
// Error and zero results return from S_GCD_GO without the gcd. busy is high for the
// whole item; one word at a time. Sync active-low reset returns to idle.
// Depends on rau_pkg, rau_gcd, rau_div.
module rational_arithmetic_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_cmd,
  input  logic signed [rau_pkg::OP_W-1:0]   in_a_num,
  input  logic [rau_pkg::DEN_W-1:0]         in_a_den,
  input  logic signed [rau_pkg::OP_W-1:0]   in_b_num,
  input  logic [rau_pkg::DEN_W-1:0]         in_b_den,
  output logic                              out_valid,
  output logic signed [63:0]                out_res_num,
  output logic [61:0]                       out_res_den,
  output logic                              out_status
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD_GO, S_GCD_WAIT,
    S_DIVN_GO, S_DIVN_WAIT, S_DIVD_GO, S_DIVD_WAIT, S_OUT
  } state_t;

  localparam int W = rau_pkg::WIDE_W;

  state_t              state_r;
  logic [1:0]          op_r;
  logic                sa_r, sb_r, rs_r, err_r;
  logic [rau_pkg::OP_W-1:0]  ma_r, mb_r;
  logic [rau_pkg::DEN_W-1:0] da_r, db_r;
  logic [W-1:0]        p1_r, p2_r, rm_r, rd_r, g_r, qn_r;
  logic [rau_pkg::OP_W-1:0]  mul_x, mul_y;
  logic [W-1:0]        prod;
  logic                s2;
  logic [rau_pkg::OP_W-1:0]  ma_in, mb_in;

  rau_pkg::unit_req_t  gcd_req, div_req;
  rau_pkg::unit_rsp_t  gcd_rsp, div_rsp;
  logic [W-1:0]        gcd_g, div_q, div_n;

  // magnitudes of the incoming numerators
  assign ma_in = in_a_num[rau_pkg::OP_W-1] ? (~in_a_num + 1'b1) : in_a_num;
  assign mb_in = in_b_num[rau_pkg::OP_W-1] ? (~in_b_num + 1'b1) : in_b_num;

  // select multiplier operands by step
  always_comb begin
    mul_x = ma_r;
    mul_y = {1'b0, db_r};
    case (state_r)
      S_MUL1: begin
        mul_x = ma_r;
        mul_y = (op_r == rau_pkg::CMD_MUL) ? mb_r : {1'b0, db_r};
      end
      S_MUL2: begin
        mul_x = mb_r;
        mul_y = {1'b0, da_r};
      end
      S_MUL3: begin
        mul_x = {1'b0, da_r};
        mul_y = (op_r == rau_pkg::CMD_DIV) ? mb_r : {1'b0, db_r};
      end
      default: ;
    endcase
  end

  assign prod = W'(mul_x) * W'(mul_y);
  assign s2   = (op_r == rau_pkg::CMD_SUB) ? !sb_r : sb_r;

  // start the gcd only for a non-zero, error-free result
  assign gcd_req.start = (state_r == S_GCD_GO) && !err_r && (rm_r != '0);
  assign div_req.start = (state_r == S_DIVN_GO) || (state_r == S_DIVD_GO);
  assign div_n         = (state_r == S_DIVN_GO) ? rm_r : rd_r;

  rau_gcd u_gcd (
    .clk(clk), .rst_n(rst_n), .req(gcd_req), .x_in(rm_r), .y_in(rd_r),
    .rsp(gcd_rsp), .g_out(gcd_g)
  );

  rau_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .dividend(div_n), .divisor(g_r),
    .rsp(div_rsp), .quotient(div_q)
  );

  // sequence the item through multiply, combine, gcd and the two divisions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start && !busy) begin
            op_r    <= in_cmd;
            sa_r    <= in_a_num[rau_pkg::OP_W-1];
            sb_r    <= in_b_num[rau_pkg::OP_W-1];
            ma_r    <= ma_in;
            mb_r    <= mb_in;
            da_r    <= in_a_den;
            db_r    <= in_b_den;
            err_r   <= (in_a_den == '0) || (in_b_den == '0) ||
                       ((in_cmd == rau_pkg::CMD_DIV) && (mb_in == '0));
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1_r    <= prod;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          p2_r    <= prod;
          state_r <= S_MUL3;
        end
        S_MUL3: begin
          rd_r    <= prod;
          state_r <= S_COMB;
        end
        S_COMB: begin
          if (op_r == rau_pkg::CMD_ADD || op_r == rau_pkg::CMD_SUB) begin
            if (sa_r == s2) begin
              rm_r <= p1_r + p2_r;
              rs_r <= sa_r;
            end else if (p1_r >= p2_r) begin
              rm_r <= p1_r - p2_r;
              rs_r <= sa_r;
            end else begin
              rm_r <= p2_r - p1_r;
              rs_r <= s2;
            end
          end else begin
            rm_r <= p1_r;
            rs_r <= sa_r != sb_r;
          end
          state_r <= S_GCD_GO;
        end
        S_GCD_GO: begin
          if (err_r || rm_r == '0) begin
            out_res_num <= '0;
            out_res_den <= 62'd1;
            out_status  <= err_r ? rau_pkg::ST_DIV0 : rau_pkg::ST_OK;
            out_valid   <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_GCD_WAIT;
          end
        end
        S_GCD_WAIT: begin
          if (gcd_rsp.done) begin
            g_r     <= gcd_g;
            state_r <= S_DIVN_GO;
          end
        end
        S_DIVN_GO:   state_r <= S_DIVN_WAIT;
        S_DIVN_WAIT: begin
          if (div_rsp.done) begin
            qn_r    <= div_q;
            state_r <= S_DIVD_GO;
          end
        end
        S_DIVD_GO:   state_r <= S_DIVD_WAIT;
        S_DIVD_WAIT: begin
          if (div_rsp.done) begin
            rd_r    <= div_q;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_res_num <= rs_r ? (W'(0) - qn_r) : qn_r;
          out_res_den <= rd_r[61:0];
          out_status  <= rau_pkg::ST_OK;
          out_valid   <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE) || gcd_rsp.busy || div_rsp.busy;

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted word did not raise busy");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res_den != '0) else $error("zero result denominator");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_res_num == '0 && out_res_den == 62'd1)
    else $error("error result not 0/1");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(gcd_rsp.busy && div_rsp.busy)) else $error("gcd and divider overlap");
`endif
endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Testbench for rational_arithmetic_unit: directed and random words checked
// against a behavioural gcd-reduction predictor. Depends on rau_pkg and the RTL.
module testbench;
  typedef struct {
    logic signed [63:0] num;
    logic [61:0]        den;
    logic               status;
  } ratio_t;

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic [1:0]                       in_cmd;
  logic signed [rau_pkg::OP_W-1:0]  in_a_num;
  logic [rau_pkg::DEN_W-1:0]        in_a_den;
  logic signed [rau_pkg::OP_W-1:0]  in_b_num;
  logic [rau_pkg::DEN_W-1:0]        in_b_den;
  logic                             out_valid;
  logic signed [63:0]               out_res_num;
  logic [61:0]                      out_res_den;
  logic                             out_status;

  ratio_t reduced_q[$];
  int     err_count = 0;
  longint cycle_count = 0;
  bit     no_gaps = 0;

  rational_arithmetic_unit uut (.*);

  // Clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
    while (x != 0 && y != 0) begin
      if (x >= y) x = x % y;
      else y = y % x;
    end
    return x + y;
  endfunction

  // Form the exact result and reduce it to lowest terms
  function automatic ratio_t reduce_op(logic [1:0] op, logic [31:0] an, logic [30:0] ad,
                                       logic [31:0] bn, logic [30:0] bd);
    ratio_t r;
    logic sa, sb, s2, rs;
    logic [63:0] ma, mb, da, db, p1, p2, rm, rd, g;
    r.num = '0; r.den = 62'd1; r.status = rau_pkg::ST_OK;
    sa = an[31]; sb = bn[31];
    ma = sa ? 64'(-an) & 64'hFFFF_FFFF : 64'(an);
    mb = sb ? 64'(-bn) & 64'hFFFF_FFFF : 64'(bn);
    da = 64'(ad); db = 64'(bd);
    if (da == 0 || db == 0 || (op == rau_pkg::CMD_DIV && mb == 0)) begin
      r.status = rau_pkg::ST_DIV0;
      return r;
    end
    case (op)
      rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
        p1 = ma * db; p2 = mb * da;
        s2 = (op == rau_pkg::CMD_SUB) ? !sb : sb;
        rd = da * db;
        if (sa == s2) begin rm = p1 + p2; rs = sa; end
        else if (p1 >= p2) begin rm = p1 - p2; rs = sa; end
        else begin rm = p2 - p1; rs = s2; end
      end
      rau_pkg::CMD_MUL: begin rm = ma * mb; rd = da * db; rs = sa ^ sb; end
      default: begin rm = ma * db; rd = da * mb; rs = sa ^ sb; end
    endcase
    if (rm == 0) return r;
    g = euclid_gcd(rm, rd);
    rm = rm / g; rd = rd / g;
    r.num = rs ? -rm : rm;
    r.den = rd[61:0];
    return r;
  endfunction

  // Send one word, with random idle cycles before it unless no_gaps is set
  task automatic send_word(logic [1:0] op, logic [31:0] an, logic [30:0] ad,
                           logic [31:0] bn, logic [30:0] bd);
    while (!no_gaps && $urandom_range(99) < 35) @(posedge clk);
    start <= 1; in_cmd <= op; in_a_num <= an; in_a_den <= ad;
    in_b_num <= bn; in_b_den <= bd;
    @(posedge clk);
    while (busy) @(posedge clk);
    reduced_q.push_back(reduce_op(op, an, ad, bn, bd));
    start <= 0;
    @(posedge clk);
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (reduced_q.size() == 0) begin
        $display("%0t unexpected word: got %0d/%0d st %0b", $time,
                 out_res_num, out_res_den, out_status);
        err_count++;
      end else begin
        ratio_t e;
        e = reduced_q.pop_front();
        if (e.num !== out_res_num || e.den !== out_res_den || e.status !== out_status) begin
          $display("%0t mismatch: expected %0d/%0d st %0b, got %0d/%0d st %0b", $time,
                   e.num, e.den, e.status, out_res_num, out_res_den, out_status);
          err_count++;
        end
      end
    end
  end

  task automatic drain();
    while (reduced_q.size() != 0) @(posedge clk);
  endtask

  // Operand extremes, every operation, divide by zero, zero denominators
  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7FFF_FFFF; mn = 32'h8000_0001;
    for (int op = 0; op < 4; op++) begin
      send_word(2'(op), mx, 31'h7FFF_FFFF, mx, 31'h7FFF_FFFF);
      send_word(2'(op), mn, 31'd1, mx, 31'd1);
      send_word(2'(op), 32'h8000_0000, 31'd3, 32'h8000_0000, 31'd5);
      send_word(2'(op), 32'd0, 31'd7, 32'd0, 31'd9);
    end
    send_word(rau_pkg::CMD_DIV, 32'd5, 31'd3, 32'd0, 31'd2);
    send_word(rau_pkg::CMD_ADD, 32'd5, 31'd0, 32'd3, 31'd2);
    send_word(rau_pkg::CMD_MUL, 32'd5, 31'd3, 32'd3, 31'd0);
    send_word(rau_pkg::CMD_SUB, 32'd7, 31'd3, 32'd7, 31'd3);
    send_word(rau_pkg::CMD_ADD, 32'(-7), 31'd3, 32'd7, 31'd3);
    send_word(rau_pkg::CMD_MUL, 32'd6, 31'd4, 32'(-10), 31'd15);
  endtask

  function automatic logic [31:0] rand_num();
    case ($urandom_range(3))
      0: return $urandom_range(20) - 10;
      1: return $urandom;
      default: return $urandom_range(2000) - 1000;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(9))
      0: return 31'd0;
      1, 2: return 31'($urandom);
      default: return 31'($urandom_range(1, 1000));
    endcase
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_word(2'($urandom_range(3)), rand_num(), rand_den(), rand_num(), rand_den());
  endtask

  initial begin
    rst_n = 0; start = 0; in_cmd = 0; in_a_num = 0; in_a_den = 1;
    in_b_num = 0; in_b_den = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    drain();
    test_random(400);
    // hold off until all results are back
    drain();
    no_gaps = 1;
    test_random(200);
    no_gaps = 0;
    test_random(400);
    drain();
    repeat (400) @(posedge clk);
    if (err_count == 0 && reduced_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
